FILE: design/bshp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_pkg
// Shared types and constants of the breadth-first shortest-hop path core.
// ----------------------------------------------------------------------------
package bshp_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = VtxW + 1;
  localparam int unsigned WeightW     = 8;
  localparam int unsigned LevelW      = 4;
  localparam int unsigned PathWeightW = 12;
  localparam int unsigned MemAddrW    = 2 * VtxW;
  localparam int unsigned MemDepth    = MaxVertices * MaxVertices;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 5;
  localparam int unsigned MaxHops     = 15;

  localparam logic [PathWeightW-1:0] PathWeightMax = '1;
  localparam logic [CntW-1:0]        VertexCountReset = CntW'(MaxVertices);

  typedef enum logic [1:0] {
    ActWrite  = 2'd0,
    ActRemove = 2'd1,
    ActSearch = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVertexCount = 1'b0,
    CfgDirected    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WrForward = 2'd0,
    WrMirror  = 2'd1,
    WrClear   = 2'd2,
    WrUnused  = 2'd3
  } wr_sel_e;

  typedef enum logic [1:0] {
    EmitNothing = 2'd0,
    EmitStep    = 2'd1,
    EmitFinal   = 2'd2,
    EmitNoPath  = 2'd3
  } emit_e;

  typedef struct packed {
    logic    capture;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    search_init;
    logic    dequeue;
    logic    scan_run;
    logic    walk_init;
    logic    walk_start;
    logic    walk_run;
    emit_e   emit;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    directed;
    logic    queue_nonempty;
    logic    scan_done;
    logic    target_ok;
    logic    walk_more;
    logic    walk_hit;
    logic    walk_miss;
    logic    out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: design/bshp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface bshp_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [bshp_pkg::VtxW-1:0]  from_vertex;
  logic [bshp_pkg::VtxW-1:0]  to_vertex;
  logic [bshp_pkg::WeightW-1:0] weight;
  logic [bshp_pkg::VtxW-1:0]  source_vertex;
  logic [bshp_pkg::VtxW-1:0]  target;

  modport source (output valid, action, from_vertex, to_vertex, weight, source_vertex,
                  target, input ready);
  modport sink   (input valid, action, from_vertex, to_vertex, weight, source_vertex,
                  target, output ready);
endinterface
`default_nettype wire

FILE: design/bshp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_out_if
// Result channel: valid/ready handshake with the path result fields.
// ----------------------------------------------------------------------------
interface bshp_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [bshp_pkg::VtxW-1:0]        path_vertex;
  logic [bshp_pkg::LevelW-1:0]      hop_level;
  logic [bshp_pkg::PathWeightW-1:0] path_weight;
  logic                             last;

  modport source (output valid, found, path_vertex, hop_level, path_weight, last,
                  input ready);
  modport sink   (input valid, found, path_vertex, hop_level, path_weight, last,
                  output ready);
endinterface
`default_nettype wire

FILE: design/bshp_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bshp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bshp_pkg::CfgIdxW-1:0]  index;
  logic [bshp_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/bshp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_datapath
// Edge weight memory, level and reached flags, frontier queue, path walk
// registers and the result output register.
// ----------------------------------------------------------------------------
module bshp_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bshp_pkg::ctrl_cmd_t cmd_i,
  output bshp_pkg::dp_status_t  status_o,
  bshp_in_if.sink               in_i,
  bshp_out_if.source            out_o,
  bshp_cfg_if.sink              cfg_i
);

  localparam int unsigned VtxW  = bshp_pkg::VtxW;
  localparam int unsigned CntW  = bshp_pkg::CntW;
  localparam int unsigned WW    = bshp_pkg::WeightW;
  localparam int unsigned LvlW  = bshp_pkg::LevelW;
  localparam int unsigned PwW   = bshp_pkg::PathWeightW;
  localparam int unsigned AddrW = bshp_pkg::MemAddrW;
  localparam int unsigned NV    = bshp_pkg::MaxVertices;

  // Configuration.
  logic [CntW-1:0] vcount_q;
  logic            directed_q;
  logic [CntW-1:0] n_used;
  logic [CntW-1:0] n_last;

  // Latched item.
  logic [1:0]      action_q;
  logic [VtxW-1:0] fv_q, tv_q, src_q, tgt_q;
  logic [WW-1:0]   weight_q;

  // Edge memory.
  logic [WW-1:0]    mem_q [bshp_pkg::MemDepth];
  logic [bshp_pkg::MemDepth-1:0] mem_vld_q;
  logic [AddrW-1:0] waddr, raddr;
  logic [WW-1:0]    wdata;
  logic [WW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [WW-1:0]    edge_w;

  // Search state.
  logic [NV-1:0]   reached_q;
  logic [LvlW-1:0] level_q [NV];
  logic [VtxW-1:0] queue_q [NV];
  logic [CntW-1:0] head_q, tail_q;
  logic [VtxW-1:0] u_q;
  logic [LvlW-1:0] lvl_u_q;
  logic [CntW-1:0] v_q;
  logic            chk_vld_q;
  logic [VtxW-1:0] chk_v_q;
  logic            issue;
  logic            scan_chk, walk_chk;
  logic            scan_new;

  // Walk state.
  logic [VtxW-1:0] cur_q;
  logic [LvlW-1:0] lvl_q;
  logic [PwW-1:0]  wsum_q;
  logic [LvlW-1:0] k_q;
  logic [PwW:0]    wsum_add;

  // Output register.
  logic            out_vld_q;
  logic            out_found_q;
  logic [VtxW-1:0] out_vtx_q;
  logic [LvlW-1:0] out_lvl_q;
  logic [PwW-1:0]  out_pw_q;
  logic            out_last_q;
  logic            out_free;

  always_comb begin
    if (vcount_q == '0) begin
      n_used = CntW'(1);
    end else if (vcount_q > CntW'(NV)) begin
      n_used = CntW'(NV);
    end else begin
      n_used = vcount_q;
    end
    n_last = n_used - CntW'(1);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= bshp_pkg::VertexCountReset;
      directed_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (bshp_pkg::cfg_reg_e'(cfg_i.index))
        bshp_pkg::CfgVertexCount: vcount_q <= cfg_i.data;
        bshp_pkg::CfgDirected:    directed_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = cmd_i.capture;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_i.valid) begin
      action_q <= in_i.action;
      fv_q     <= in_i.from_vertex;
      tv_q     <= in_i.to_vertex;
      weight_q <= in_i.weight;
      src_q    <= in_i.source_vertex;
      tgt_q    <= in_i.target;
    end
  end

  // Memory write and read addresses.
  always_comb begin
    unique case (cmd_i.wr_sel)
      bshp_pkg::WrForward: begin
        waddr = {fv_q, tv_q};
        wdata = weight_q;
      end
      bshp_pkg::WrMirror: begin
        waddr = {tv_q, fv_q};
        wdata = weight_q;
      end
      default: begin
        waddr = {fv_q, tv_q};
        wdata = '0;
      end
    endcase
    if (cmd_i.walk_run) begin
      raddr = {v_q[VtxW-1:0], cur_q};
    end else begin
      raddr = {u_q, v_q[VtxW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    rd_data_q <= mem_q[raddr];
    rd_vld_q  <= mem_vld_q[raddr];
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      mem_vld_q[waddr] <= 1'b1;
    end
  end

  assign edge_w   = rd_vld_q ? rd_data_q : '0;
  assign issue    = (cmd_i.scan_run || cmd_i.walk_run) && (v_q < n_used);
  assign scan_chk = cmd_i.scan_run && chk_vld_q;
  assign walk_chk = cmd_i.walk_run && chk_vld_q;
  assign scan_new = scan_chk && (edge_w != '0) && !reached_q[chk_v_q]
                    && (tail_q < CntW'(NV));

  assign wsum_add = {1'b0, wsum_q} + (PwW+1)'(edge_w);

  // Scan pipeline: read issue and the check of the previous read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      reached_q <= '0;
      v_q       <= '0;
    end else begin
      chk_vld_q <= issue && !status_o.walk_hit;
      if (issue) begin
        v_q <= v_q + CntW'(1);
      end
      if (cmd_i.dequeue || cmd_i.walk_start) begin
        v_q <= '0;
      end
      if (cmd_i.search_init) begin
        head_q    <= '0;
        reached_q <= '0;
        if ({1'b0, src_q} < n_used) begin
          reached_q[src_q] <= 1'b1;
          tail_q           <= CntW'(1);
        end else begin
          tail_q <= '0;
        end
      end
      if (cmd_i.dequeue) begin
        head_q <= head_q + CntW'(1);
      end
      if (scan_new) begin
        reached_q[chk_v_q] <= 1'b1;
        tail_q             <= tail_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_v_q <= v_q[VtxW-1:0];
    if (cmd_i.search_init) begin
      level_q[src_q] <= '0;
      queue_q[0]     <= src_q;
    end
    if (cmd_i.dequeue) begin
      u_q     <= queue_q[head_q[VtxW-1:0]];
      lvl_u_q <= level_q[queue_q[head_q[VtxW-1:0]]];
    end
    if (scan_new) begin
      level_q[chk_v_q]             <= lvl_u_q + LvlW'(1);
      queue_q[tail_q[VtxW-1:0]]    <= chk_v_q;
    end
    if (cmd_i.walk_init) begin
      cur_q  <= tgt_q;
      lvl_q  <= level_q[tgt_q];
      wsum_q <= '0;
      k_q    <= '0;
    end
    if (status_o.walk_hit) begin
      cur_q <= chk_v_q;
      lvl_q <= lvl_q - LvlW'(1);
      k_q   <= k_q + LvlW'(1);
      if (wsum_add[PwW]) begin
        wsum_q <= bshp_pkg::PathWeightMax;
      end else begin
        wsum_q <= wsum_add[PwW-1:0];
      end
    end
  end

  // Result register.
  assign out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit != bshp_pkg::EmitNothing) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.emit)
      bshp_pkg::EmitStep: begin
        out_found_q <= 1'b1;
        out_vtx_q   <= cur_q;
        out_lvl_q   <= lvl_q;
        out_pw_q    <= '0;
        out_last_q  <= 1'b0;
      end
      bshp_pkg::EmitFinal: begin
        out_found_q <= 1'b1;
        out_vtx_q   <= cur_q;
        out_lvl_q   <= lvl_q;
        out_pw_q    <= wsum_q;
        out_last_q  <= 1'b1;
      end
      bshp_pkg::EmitNoPath: begin
        out_found_q <= 1'b0;
        out_vtx_q   <= '0;
        out_lvl_q   <= '0;
        out_pw_q    <= '0;
        out_last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.found       = out_found_q;
  assign out_o.path_vertex = out_vtx_q;
  assign out_o.hop_level   = out_lvl_q;
  assign out_o.path_weight = out_pw_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    status_o.action         = bshp_pkg::action_e'(cmd_i.capture ? in_i.action : action_q);
    status_o.directed       = directed_q;
    status_o.queue_nonempty = head_q < tail_q;
    status_o.scan_done      = scan_chk && ({1'b0, chk_v_q} == n_last);
    status_o.target_ok      = ({1'b0, tgt_q} < n_used) && reached_q[tgt_q];
    status_o.walk_more      = (lvl_q != '0) && (k_q < LvlW'(bshp_pkg::MaxHops));
    status_o.walk_hit       = walk_chk && reached_q[chk_v_q]
                              && (level_q[chk_v_q] == lvl_q - LvlW'(1)) && (edge_w != '0);
    status_o.walk_miss      = walk_chk && !status_o.walk_hit
                              && ({1'b0, chk_v_q} == n_last);
    status_o.out_free       = out_free;
  end

endmodule
`default_nettype wire

FILE: design/bshp_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bshp_controller
// Sequencer for edge writes, the breadth-first scan and the path walk.
// ----------------------------------------------------------------------------
module bshp_controller (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire bshp_pkg::dp_status_t status_i,
  output bshp_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    StIdle     = 11'b000_0000_0001,
    StWrite    = 11'b000_0000_0010,
    StMirror   = 11'b000_0000_0100,
    StRemove   = 11'b000_0000_1000,
    StInit     = 11'b000_0001_0000,
    StDequeue  = 11'b000_0010_0000,
    StScan     = 11'b000_0100_0000,
    StWalkInit = 11'b000_1000_0000,
    StWalkChk  = 11'b001_0000_0000,
    StWalkEmit = 11'b010_0000_0000,
    StWalkScan = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   final_q, final_d;   // Walk done: the final result is pending.
  logic   nopath_q, nopath_d; // Target unreachable: the no-path result is pending.

  always_comb begin
    state_d  = state_q;
    final_d  = final_q;
    nopath_d = nopath_q;
    cmd_o    = '0;
    cmd_o.wr_sel = bshp_pkg::WrForward;
    cmd_o.emit   = bshp_pkg::EmitNothing;
    unique case (state_q)
      StIdle: begin
        if (final_q) begin
          if (status_i.out_free) begin
            cmd_o.emit = bshp_pkg::EmitFinal;
            final_d    = 1'b0;
          end
        end else if (nopath_q) begin
          if (status_i.out_free) begin
            cmd_o.emit = bshp_pkg::EmitNoPath;
            nopath_d   = 1'b0;
          end
        end else begin
          cmd_o.capture = 1'b1;
          if (in_valid_i) begin
            unique case (status_i.action)
              bshp_pkg::ActWrite:  state_d = StWrite;
              bshp_pkg::ActRemove: state_d = StRemove;
              bshp_pkg::ActSearch: state_d = StInit;
              default:             state_d = StIdle;
            endcase
          end
        end
      end
      StWrite: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bshp_pkg::WrForward;
        state_d      = status_i.directed ? StIdle : StMirror;
      end
      StMirror: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bshp_pkg::WrMirror;
        state_d      = StIdle;
      end
      StRemove: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bshp_pkg::WrClear;
        state_d      = StIdle;
      end
      StInit: begin
        cmd_o.search_init = 1'b1;
        state_d           = StDequeue;
      end
      StDequeue: begin
        if (status_i.queue_nonempty) begin
          cmd_o.dequeue = 1'b1;
          state_d       = StScan;
        end else begin
          state_d = StWalkInit;
        end
      end
      StScan: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.scan_done) begin
          state_d = StDequeue;
        end
      end
      StWalkInit: begin
        if (status_i.target_ok) begin
          cmd_o.walk_init = 1'b1;
          state_d         = StWalkChk;
        end else begin
          nopath_d = 1'b1;
          state_d  = StIdle;
        end
      end
      StWalkChk: begin
        if (status_i.walk_more) begin
          state_d = StWalkEmit;
        end else begin
          final_d = 1'b1;
          state_d = StIdle;
        end
      end
      StWalkEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit       = bshp_pkg::EmitStep;
          cmd_o.walk_start = 1'b1;
          state_d          = StWalkScan;
        end
      end
      StWalkScan: begin
        cmd_o.walk_run = 1'b1;
        if (status_i.walk_hit) begin
          state_d = StWalkChk;
        end else if (status_i.walk_miss) begin
          final_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      final_q  <= 1'b0;
      nopath_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      final_q  <= final_d;
      nopath_q <= nopath_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/bfs_shortest_hop_path_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_shortest_hop_path_core
// Breadth-first shortest-hop path search over a stored adjacency matrix.
// ----------------------------------------------------------------------------
// Edge write: the forward entry, then the mirrored entry when undirected; edge
// remove: the forward entry only. Search: a row scan for each reached vertex,
// paced by the single read port of the edge memory, then a column scan per
// path hop.
// Items are taken one at a time; one result register decouples the output.
// Reset is asynchronous and immediate: per-entry valid bits zero the matrix.
// ----------------------------------------------------------------------------
module bfs_shortest_hop_path_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bshp_in_if.sink    in_i,
  bshp_out_if.source out_o,
  bshp_cfg_if.sink   cfg_i
);

  bshp_pkg::ctrl_cmd_t  cmd;
  bshp_pkg::dp_status_t status;

  bshp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bshp_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i)
  );

endmodule
`default_nettype wire

FILE: dv/tb_bshp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bshp_pkg
// Path predictor for the breadth-first shortest-hop path core testbench.
// ----------------------------------------------------------------------------
package tb_bshp_pkg;
  import bshp_pkg::*;

  typedef struct packed {
    action_e                action;
    logic [VtxW-1:0]        from_vertex;
    logic [VtxW-1:0]        to_vertex;
    logic [WeightW-1:0]     weight;
    logic [VtxW-1:0]        source;
    logic [VtxW-1:0]        target;
  } path_req_t;

  typedef struct packed {
    logic                   found;
    logic [VtxW-1:0]        path_vertex;
    logic [LevelW-1:0]      hop_level;
    logic [PathWeightW-1:0] path_weight;
    logic                   last;
  } path_word_t;

  class graph_model;
    logic [WeightW-1:0] adj [MaxVertices][MaxVertices];
    int unsigned        vcount;
    bit                 is_directed;

    function void clear();
      foreach (adj[r, c]) adj[r][c] = '0;
      vcount      = MaxVertices;
      is_directed = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
      if (idx == CfgVertexCount) vcount = 32'(val);
      else is_directed = val[0];
    endfunction

    // Applies one request and appends the path words it produces.
    function void apply(path_req_t rq, ref path_word_t words[$]);
      int unsigned n, head, tail, cur, lvl, prev, wsum, k;
      int unsigned lev [MaxVertices];
      bit          seen [MaxVertices];
      int unsigned fifo [MaxVertices];
      path_word_t  w;
      case (rq.action)
        ActWrite: begin
          adj[rq.from_vertex][rq.to_vertex] = rq.weight;
          if (!is_directed) adj[rq.to_vertex][rq.from_vertex] = rq.weight;
        end
        ActRemove: adj[rq.from_vertex][rq.to_vertex] = '0;
        ActSearch: begin
          n = (vcount == 0) ? 1 : (vcount > MaxVertices ? MaxVertices : vcount);
          foreach (seen[i]) begin
            seen[i] = 0;
            lev[i]  = 0;
          end
          head = 0;
          tail = 0;
          if (rq.source < n) begin
            seen[rq.source] = 1;
            fifo[tail++] = 32'(rq.source);
          end
          while (head < tail && head < MaxVertices) begin
            cur = fifo[head++];
            for (int v = 0; v < n; v++)
              if (adj[cur][v] != 0 && !seen[v] && tail < MaxVertices) begin
                seen[v] = 1;
                lev[v]  = lev[cur] + 1;
                fifo[tail++] = v;
              end
          end
          if (rq.target >= n || !seen[rq.target]) begin
            w = '0;
            w.last = 1'b1;
            words.push_back(w);
          end else begin
            cur  = 32'(rq.target);
            lvl  = lev[cur];
            wsum = 0;
            k    = 0;
            while (lvl > 0 && k < MaxHops) begin
              w = '{1'b1, cur[VtxW-1:0], lvl[LevelW-1:0], '0, 1'b0};
              words.push_back(w);
              k++;
              prev = n;
              for (int v = 0; v < n; v++)
                if (seen[v] && lev[v] == lvl - 1 && adj[v][cur] != 0) begin
                  prev = v;
                  break;
                end
              if (prev >= n) break;
              wsum += 32'(adj[prev][cur]);
              if (wsum > 32'(PathWeightMax)) wsum = 32'(PathWeightMax);
              cur = prev;
              lvl--;
            end
            w = '{1'b1, cur[VtxW-1:0], lvl[LevelW-1:0], wsum[PathWeightW-1:0], 1'b1};
            words.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction
  endclass
endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives edge writes, removals and searches into the path core, predicts each
// path word and compares every returned word field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bshp_pkg::*;
  import tb_bshp_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bshp_in_if  req_if ();
  bshp_out_if word_if ();
  bshp_cfg_if cfg_if ();

  bfs_shortest_hop_path_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (word_if),
    .cfg_i (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  graph_model  golden;
  path_word_t  expected_words[$];
  int unsigned error_count  = 0;
  int unsigned word_count   = 0;
  int unsigned search_count = 0;
  int unsigned idle_cycles  = 0;
  bit          sender_gaps  = 1'b1;
  bit          receiver_gaps = 1'b1;
  bit          hold_req     = 1'b0;
  int unsigned hold_off     = 0;

  initial begin
    req_if.valid         = 1'b0;
    req_if.action        = '0;
    req_if.from_vertex   = '0;
    req_if.to_vertex     = '0;
    req_if.weight        = '0;
    req_if.source_vertex = '0;
    req_if.target        = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    word_if.ready        = 1'b0;
  end

  // The receiver idles at random, or for a counted hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_off      <= 3000;
      word_if.ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      word_if.ready <= 1'b0;
    end else begin
      word_if.ready <= !receiver_gaps || ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    path_word_t got, want;
    if (rst_ni && word_if.valid && word_if.ready) begin
      got = '{word_if.found, word_if.path_vertex, word_if.hop_level,
              word_if.path_weight, word_if.last};
      word_count++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: word mismatch, expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (word_if.valid && word_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_req(path_req_t rq);
    while (sender_gaps && $urandom_range(99) < 27) @(posedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.action        <= rq.action;
    req_if.from_vertex   <= rq.from_vertex;
    req_if.to_vertex     <= rq.to_vertex;
    req_if.weight        <= rq.weight;
    req_if.source_vertex <= rq.source;
    req_if.target        <= rq.target;
    do @(posedge clk_i); while (!req_if.ready);
    golden.apply(rq, expected_words);
    if (rq.action == ActSearch) search_count++;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    golden.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic path_req_t edge_req(action_e a, int f, int t, int w);
    path_req_t rq;
    rq = '0;
    rq.action = a;
    rq.from_vertex = VtxW'(f);
    rq.to_vertex = VtxW'(t);
    rq.weight = WeightW'(w);
    rq.source = VtxW'($urandom);
    rq.target = VtxW'($urandom);
    return rq;
  endfunction

  function automatic path_req_t search_req(int s, int t);
    path_req_t rq;
    rq = '0;
    rq.action = ActSearch;
    rq.source = VtxW'(s);
    rq.target = VtxW'(t);
    rq.from_vertex = VtxW'($urandom);
    rq.to_vertex = VtxW'($urandom);
    rq.weight = WeightW'($urandom);
    return rq;
  endfunction

  task automatic test_directed_cases();
    send_req(search_req(0, 0));
    send_req(search_req(3, 7));
    send_req(edge_req(ActWrite, 0, 1, 255));
    send_req(edge_req(ActWrite, 1, 15, 255));
    send_req(edge_req(ActWrite, 15, 14, 1));
    send_req(search_req(0, 14));
    send_req(search_req(14, 0));
    send_req(edge_req(ActRemove, 1, 0, 0));
    send_req(search_req(1, 0));
    send_req(edge_req(ActNone, 2, 3, 9));
    send_req(edge_req(ActWrite, 5, 6, 0));
    send_req(search_req(5, 6));
    // A chain through every vertex with heavy weights, searched end to end.
    for (int i = 0; i < 15; i++) send_req(edge_req(ActWrite, i, i + 1, 255));
    send_req(search_req(0, 15));
    send_req(search_req(15, 0));
  endtask

  task automatic test_vertex_count();
    write_reg(CfgVertexCount, CfgDataW'(0));
    send_req(search_req(0, 0));
    send_req(search_req(0, 1));
    write_reg(CfgVertexCount, CfgDataW'(31));
    send_req(search_req(0, 15));
    write_reg(CfgVertexCount, CfgDataW'(4));
    send_req(search_req(0, 3));
    send_req(search_req(0, 9));
    send_req(search_req(9, 9));
    write_reg(CfgVertexCount, CfgDataW'(16));
  endtask

  task automatic random_phase(int unsigned items, int unsigned vmax);
    path_req_t rq;
    for (int unsigned i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: rq = edge_req(ActWrite, $urandom_range(vmax), $urandom_range(vmax),
                                  ($urandom_range(9) == 0) ? 0 : $urandom);
        4: rq = edge_req(ActRemove, $urandom_range(vmax), $urandom_range(vmax), $urandom);
        5: rq = edge_req(ActWrite, $urandom, $urandom, $urandom);
        6: rq = edge_req(ActNone, $urandom, $urandom, $urandom);
        default: rq = search_req($urandom_range(vmax), $urandom_range(vmax));
      endcase
      if (rq.action == ActNone) i--;
      send_req(rq);
    end
  endtask

  task automatic test_random_settings();
    write_reg(CfgDirected, CfgDataW'(1));
    random_phase(80, 15);
    write_reg(CfgVertexCount, CfgDataW'(6));
    random_phase(70, 7);
    write_reg(CfgDirected, CfgDataW'(0));
    write_reg(CfgVertexCount, CfgDataW'(1));
    random_phase(30, 3);
    write_reg(CfgVertexCount, CfgDataW'(16));
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    random_phase(60, 15);
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    random_phase(60, 15);
  endtask

  task automatic test_pressure();
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    for (int i = 0; i < 8; i++) send_req(search_req(0, 15 - i));
    while (expected_words.size() != 0) @(posedge clk_i);
    send_req(search_req(2, 9));
  endtask

  initial begin
    golden = new();
    golden.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_vertex_count();
    test_pressure();
    test_random_settings();
    drain();
    $display("Covered %0d searches and %0d path words over directed, undirected and",
             search_count, word_count);
    $display("vertex counts 0, 1, 4, 6, 16 and 31, with idling and a long receiver stall.");
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule

FILE: files.f
design/bshp_pkg.sv
design/bshp_in_if.sv
design/bshp_out_if.sv
design/bshp_cfg_if.sv
design/bshp_datapath.sv
design/bshp_controller.sv
design/bfs_shortest_hop_path_core.sv
dv/tb_bshp_pkg.sv
dv/tb_top.sv
